// File: design/sfa_pkg.sv
// Shared types, widths and constants of the sprite frame animation sequencer.
package sfa_pkg;

  localparam int ALW  = 5;   // anim_length register
  localparam int DIMW = 13;  // sheet and frame size registers
  localparam int CFGW = 13;  // configuration write data
  localparam int CIW  = 3;   // configuration register index
  localparam int FRW  = 12;  // sheet frame index, pixel coordinates
  localparam int DURW = 24;  // entry duration and tick time
  localparam int EW   = 25;  // elapsed time
  localparam int TPW  = 4;   // reported table position

  localparam logic [DURW-1:0] DEFAULT_DURATION = 24'd100000;

  localparam logic [ALW-1:0]  RST_ANIM_LENGTH   = 5'd1;
  localparam logic            RST_LOOP_ENABLE   = 1'b1;
  localparam logic [DIMW-1:0] RST_SHEET_COLUMNS = 13'd1;
  localparam logic [DIMW-1:0] RST_SHEET_FRAMES  = 13'd1;
  localparam logic [DIMW-1:0] RST_FRAME_WIDTH   = 13'd16;
  localparam logic [DIMW-1:0] RST_FRAME_HEIGHT  = 13'd16;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_REWIND = 2'd2
  } cmd_t;

  typedef enum logic [CIW-1:0] {
    REG_ANIM_LENGTH   = 3'd0,
    REG_LOOP_ENABLE   = 3'd1,
    REG_SHEET_COLUMNS = 3'd2,
    REG_SHEET_FRAMES  = 3'd3,
    REG_FRAME_WIDTH   = 3'd4,
    REG_FRAME_HEIGHT  = 3'd5
  } cfg_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic step;       // test the current duration, advance if it has run out
    logic div_start;  // latch the sheet index, start the divider
    logic out_load;   // load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tick_run;   // offered item is a tick on an unfinished animation
    logic step_last;  // no further step follows the current one
    logic div_done;
    logic out_free;   // result register empty or being taken
  } dp_status_t;

endpackage

// File: design/sfa_div.sv
// Restoring divider: sheet index by column count, one quotient bit per cycle.
module sfa_div import sfa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [FRW-1:0]  dividend,
  input  logic [DIMW-1:0] divisor,
  output logic            done,
  output logic [FRW-1:0]  quot,
  output logic [DIMW-1:0] rem
);

  localparam int CW = $clog2(FRW + 1);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [FRW-1:0]  dvd;
  logic [DIMW-1:0] rem_r;
  logic [DIMW-1:0] dsr;
  logic [DIMW:0]   trial;
  logic [DIMW:0]   diff;
  logic            fits;
  logic [DIMW-1:0] rem_next;

  always_comb begin
    trial    = {rem_r, dvd[FRW-1]};
    diff     = trial - {1'b0, dsr};
    fits     = trial >= {1'b0, dsr};
    rem_next = fits ? diff[DIMW-1:0] : trial[DIMW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(FRW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dsr   <= divisor;
      rem_r <= '0;
    end else if (busy) begin
      dvd   <= {dvd[FRW-2:0], fits};
      rem_r <= rem_next;
    end
  end

  assign quot = dvd;
  assign rem  = rem_r;

endmodule

// File: design/sfa_dp.sv
// Datapath: configuration, animation tables, timing state, divider and result register.
module sfa_dp import sfa_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int MAX_STEPS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        ctl,
  output dp_status_t       status,
  input  logic             cfg_we,
  input  logic [CIW-1:0]   cfg_index,
  input  logic [CFGW-1:0]  cfg_data,
  input  logic [1:0]       cmd,
  input  logic [3:0]       entry_index,
  input  logic [FRW-1:0]   entry_frame,
  input  logic [DURW-1:0]  entry_duration,
  input  logic [DURW-1:0]  dt,
  input  logic             res_stall,
  output logic             res_valid,
  output logic [FRW-1:0]   rect_x,
  output logic [FRW-1:0]   rect_y,
  output logic [DIMW-1:0]  rect_w,
  output logic [DIMW-1:0]  rect_h,
  output logic [TPW-1:0]   table_position,
  output logic             rect_valid,
  output logic             done_res
);

  localparam int PW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int LW = $clog2(FRAMES + 1);
  localparam int SW = $clog2(MAX_STEPS + 1);

  // configuration
  logic [ALW-1:0]  anim_length;
  logic            loop_enable;
  logic [DIMW-1:0] sheet_columns;
  logic [DIMW-1:0] sheet_frames;
  logic [DIMW-1:0] frame_width;
  logic [DIMW-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      anim_length   <= RST_ANIM_LENGTH;
      loop_enable   <= RST_LOOP_ENABLE;
      sheet_columns <= RST_SHEET_COLUMNS;
      sheet_frames  <= RST_SHEET_FRAMES;
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ANIM_LENGTH:   anim_length   <= cfg_data[ALW-1:0];
        REG_LOOP_ENABLE:   loop_enable   <= cfg_data[0];
        REG_SHEET_COLUMNS: sheet_columns <= cfg_data;
        REG_SHEET_FRAMES:  sheet_frames  <= cfg_data;
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // animation tables; an entry never loaded since reset is taken as frame 0 with the default duration
  logic [FRW-1:0]  frm_mem [FRAMES];
  logic [DURW-1:0] dur_mem [FRAMES];
  logic [FRAMES-1:0] tbl_valid;
  logic [FRW-1:0]  frm_q;
  logic [DURW-1:0] dur_q;
  logic            tv_q;
  logic [PW-1:0]   position;
  logic            load_wr;
  logic [PW-1:0]   wr_addr;

  assign load_wr = ctl.accept && (cmd == CMD_LOAD) && (32'(entry_index) < FRAMES);
  assign wr_addr = PW'(entry_index);

  always_ff @(posedge clk) begin
    if (load_wr) begin
      frm_mem[wr_addr] <= entry_frame;
      dur_mem[wr_addr] <= (entry_duration == '0) ? DURW'(1) : entry_duration;
    end
    frm_q <= frm_mem[position];
    dur_q <= dur_mem[position];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
      tv_q      <= 1'b0;
    end else begin
      if (load_wr) tbl_valid[wr_addr] <= 1'b1;
      tv_q <= tbl_valid[position];
    end
  end

  // timing state
  logic [EW-1:0]   elapsed;
  logic            finished;
  logic [SW-1:0]   steps;
  logic [LW-1:0]   len;
  logic [EW:0]     sum;
  logic [DURW-1:0] d_eff;
  logic            run_out;
  logic [LW-1:0]   pos_inc;
  logic            at_end;
  logic [SW-1:0]   steps_inc;

  always_comb begin
    if (anim_length == '0) begin
      len = LW'(1);
    end else if (32'(anim_length) > FRAMES) begin
      len = LW'(FRAMES);
    end else begin
      len = LW'(anim_length);
    end
    sum       = {1'b0, elapsed} + {2'b00, dt};
    d_eff     = tv_q ? dur_q : DEFAULT_DURATION;
    run_out   = elapsed >= {1'b0, d_eff};
    pos_inc   = LW'(position) + LW'(1);
    at_end    = pos_inc >= len;
    steps_inc = steps + SW'(1);
  end

  assign status.tick_run  = (cmd == CMD_TICK) && !finished;
  assign status.step_last = !run_out || (at_end && !loop_enable) ||
                            (steps_inc == SW'(MAX_STEPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      elapsed  <= '0;
      finished <= 1'b0;
      steps    <= '0;
    end else if (ctl.accept) begin
      steps <= '0;
      if (cmd == CMD_REWIND) begin
        position <= '0;
        elapsed  <= '0;
        finished <= 1'b0;
      end else if (status.tick_run) begin
        // saturate before stepping
        elapsed <= sum[EW] ? '1 : sum[EW-1:0];
      end
    end else if (ctl.step && run_out) begin
      elapsed <= elapsed - {1'b0, d_eff};
      steps   <= steps_inc;
      if (at_end) begin
        if (loop_enable) begin
          position <= '0;
        end else begin
          position <= PW'(len - LW'(1));
          finished <= 1'b1;
        end
      end else begin
        position <= PW'(pos_inc);
      end
    end
  end

  // rectangle of the current sheet frame
  logic [FRW-1:0]  idx;
  logic            idx_ok;
  logic [DIMW-1:0] cols_eff;
  logic [FRW-1:0]  row;
  logic [DIMW-1:0] col;
  logic [FRW-1:0]  px;
  logic [FRW-1:0]  py;

  assign idx      = tv_q ? frm_q : '0;
  assign cols_eff = (sheet_columns == '0) ? DIMW'(1) : sheet_columns;

  always_ff @(posedge clk) begin
    if (ctl.div_start) idx_ok <= {1'b0, idx} < sheet_frames;
  end

  sfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (idx),
    .divisor  (cols_eff),
    .done     (status.div_done),
    .quot     (row),
    .rem      (col)
  );

  // only the low 12 bits of each product are kept
  assign px = col[FRW-1:0] * frame_width[FRW-1:0];
  assign py = row * frame_height[FRW-1:0];

  assign status.out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rect_x         <= idx_ok ? px : '0;
      rect_y         <= idx_ok ? py : '0;
      rect_w         <= idx_ok ? frame_width : '0;
      rect_h         <= idx_ok ? frame_height : '0;
      rect_valid     <= idx_ok;
      table_position <= TPW'(position);
      done_res       <= finished;
    end
  end

endmodule

// File: design/sfa_ctrl.sv
// Controller: stepping (ticks only), then index lookup, division and result per item.
module sfa_ctrl import sfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP_CMP,
    S_STEP_RD,
    S_RECT_RD,
    S_RECT_IDX,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  always_comb begin
    item_stall    = (state != S_IDLE);
    ctl.accept    = (state == S_IDLE) && item_valid;
    ctl.step      = (state == S_STEP_CMP);
    ctl.div_start = (state == S_RECT_IDX);
    ctl.out_load  = (state == S_OUT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) state <= status.tick_run ? S_STEP_CMP : S_RECT_RD;
        end
        S_STEP_CMP: begin
          state <= status.step_last ? S_RECT_RD : S_STEP_RD;
        end
        // wait for the duration of the new position
        S_STEP_RD:  state <= S_STEP_CMP;
        S_RECT_RD:  state <= S_RECT_IDX;
        S_RECT_IDX: state <= S_DIV;
        S_DIV: begin
          if (status.div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/sprite_frame_animation_sequencer.sv
// Top level of the sprite frame animation sequencer.
//
//   channel  signals                      direction  transfer when
//   item     item_valid, item_stall       in         item_valid && !item_stall
//   result   res_valid, res_stall         out        res_valid && !res_stall
//   config   cfg_we, cfg_index, cfg_data  in         cfg_we
//
// One item is worked on at a time. Load, rewind, unused commands and ticks on a finished
// animation pass through the table read, the divider and the result register; a tick on
// an unfinished animation first tests durations, up to MAX_STEPS times, with a table read
// per step. The divider works out the 12 quotient bits one by one, then sets its done flag.
// Synchronous reset returns control and timing state, configuration and table valid bits to their reset values.
// A stalled result is held while the next item is already being worked on.
module sprite_frame_animation_sequencer import sfa_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int MAX_STEPS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [CIW-1:0]  cfg_index,
  input  logic [CFGW-1:0] cfg_data,
  input  logic            item_valid,
  output logic            item_stall,
  input  logic [1:0]      cmd,
  input  logic [3:0]      entry_index,
  input  logic [FRW-1:0]  entry_frame,
  input  logic [DURW-1:0] entry_duration,
  input  logic [DURW-1:0] dt,
  output logic            res_valid,
  input  logic            res_stall,
  output logic [FRW-1:0]  rect_x,
  output logic [FRW-1:0]  rect_y,
  output logic [DIMW-1:0] rect_w,
  output logic [DIMW-1:0] rect_h,
  output logic [TPW-1:0]  table_position,
  output logic            rect_valid,
  output logic            done_res
);

  ctrl_cmd_t  ctl;
  dp_status_t status;

  sfa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .ctl        (ctl)
  );

  sfa_dp #(
    .FRAMES    (FRAMES),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .entry_index    (entry_index),
    .entry_frame    (entry_frame),
    .entry_duration (entry_duration),
    .dt             (dt),
    .res_stall      (res_stall),
    .res_valid      (res_valid),
    .rect_x         (rect_x),
    .rect_y         (rect_y),
    .rect_w         (rect_w),
    .rect_h         (rect_h),
    .table_position (table_position),
    .rect_valid     (rect_valid),
    .done_res       (done_res)
  );

endmodule
